/* hdl/bgce_pkg.sv */
`default_nettype none

package bgce_pkg;

    localparam int MEM_BYTES_DEF = 1024;

    // Cursor width covers any offset from the input fields; offset plus count can need one bit more.
    localparam int CUR_W = 14;

    localparam logic [2:0] CMD_WRITE = 3'd0;
    localparam logic [2:0] CMD_READ  = 3'd1;
    localparam logic [2:0] CMD_COPY  = 3'd2;
    localparam logic [2:0] CMD_ZERO  = 3'd3;
    localparam logic [2:0] CMD_ONE   = 3'd4;

    localparam logic [7:0] FILL_ONES  = 8'hff;
    localparam logic [7:0] FILL_ZEROS = 8'h00;

    typedef struct packed {
        logic [2:0]  command;
        logic [9:0]  byte_address;
        logic [7:0]  byte_data;
        logic [12:0] src_bit_offset;
        logic [12:0] dst_bit_offset;
        logic [13:0] bit_count;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       status;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic decode;
        logic wr_byte;
        logic rd_byte;
        logic cap_rd;
        logic rd_src;
        logic rd_dst;
        logic latch_chunk;
        logic wr_lo;
        logic wr_hi;
    } t_dp_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_write;
        logic is_read;
        logic is_copy;
        logic is_fill;
        logic err;
        logic left_zero;
        logic spill;
    } t_dp_stat;

endpackage

`default_nettype wire

/* hdl/bgce_ram.sv */
`default_nettype none

module bgce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr_a,
    input  wire logic [AW-1:0]    i_raddr_b,
    output logic      [WIDTH-1:0] o_rdata_a,
    output logic      [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

/* hdl/bgce_ctrl.sv */
`default_nettype none

module bgce_ctrl
    import bgce_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    output logic          busy,
    output logic          o_valid,
    input  wire t_dp_stat i_stat,
    output t_dp_ctl       o_ctl
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_RDW  = 3'd2;
    localparam logic [2:0] S_SRC  = 3'd3;
    localparam logic [2:0] S_DST  = 3'd4;
    localparam logic [2:0] S_MRG  = 3'd5;
    localparam logic [2:0] S_HI   = 3'd6;
    localparam logic [2:0] S_RES  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       take;

    assign busy    = (r_state != S_IDLE) && (r_state != S_RES);
    assign o_valid = (r_state == S_RES);
    assign take    = start && !busy;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_ctl.load = take;
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                o_ctl.decode = 1'b1;
                if (i_stat.err) begin
                    n_state = S_RES;
                end else if (i_stat.is_write) begin
                    o_ctl.wr_byte = 1'b1;
                    n_state = S_RES;
                end else if (i_stat.is_read) begin
                    o_ctl.rd_byte = 1'b1;
                    n_state = S_RDW;
                end else if (i_stat.is_copy || i_stat.is_fill) begin
                    n_state = S_SRC;
                end else begin
                    n_state = S_RES;
                end
            end
            S_RDW: begin
                o_ctl.cap_rd = 1'b1;
                n_state = S_RES;
            end
            S_SRC: begin
                if (i_stat.left_zero) begin
                    n_state = S_RES;
                end else begin
                    // Fills have a constant source and need no read here.
                    o_ctl.rd_src = i_stat.is_copy;
                    n_state = S_DST;
                end
            end
            S_DST: begin
                o_ctl.latch_chunk = 1'b1;
                o_ctl.rd_dst = 1'b1;
                n_state = S_MRG;
            end
            S_MRG: begin
                o_ctl.wr_lo = 1'b1;
                n_state = i_stat.spill ? S_HI : S_SRC;
            end
            S_HI: begin
                o_ctl.wr_hi = 1'b1;
                n_state = S_SRC;
            end
            S_RES: begin
                n_state = take ? S_DEC : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* hdl/bgce_dp.sv */
`default_nettype none

module bgce_dp
    import bgce_pkg::*;
#(
    parameter int MEM_BYTES = MEM_BYTES_DEF
) (
    input  wire logic     i_clk,
    input  wire t_in_item i_item,
    input  wire t_dp_ctl  i_ctl,
    output t_dp_stat      o_stat,
    output t_out_item     o_result
);

    localparam int AW         = $clog2(MEM_BYTES);
    localparam int TOTAL_BITS = MEM_BYTES * 8;

    logic [2:0]       r_cmd;
    logic [9:0]       r_addr;
    logic [7:0]       r_data;
    logic [CUR_W-1:0] r_src;
    logic [CUR_W-1:0] r_dst;
    logic [13:0]      r_left;
    logic [7:0]       r_chunk;
    logic [7:0]       r_hi_data;
    logic [AW-1:0]    r_hi_addr;
    logic [7:0]       r_rd_data;
    logic             r_status;

    logic [AW-1:0]    src_idx;
    logic [AW-1:0]    dst_idx;
    logic [AW-1:0]    ra_a;
    logic [AW-1:0]    ra_b;
    logic [7:0]       rd_a;
    logic [7:0]       rd_b;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [7:0]       wdata;

    logic [3:0]       len;
    logic [4:0]       reach;
    logic [15:0]      src_word;
    logic [15:0]      dst_word;
    logic [8:0]       len_mask;
    logic [15:0]      mask16;
    logic [15:0]      data16;
    logic [15:0]      merged;
    logic [14:0]      src_end;
    logic [14:0]      dst_end;
    logic             addr_err;
    logic             src_err;
    logic             dst_err;
    logic             is_fill;

    assign src_idx = AW'(r_src[CUR_W-1:3]);
    assign dst_idx = AW'(r_dst[CUR_W-1:3]);

    assign len   = (r_left > 14'd8) ? 4'd8 : r_left[3:0];
    assign reach = 5'(r_dst[2:0]) + 5'(len);

    assign src_end  = 15'(r_src) + 15'(r_left);
    assign dst_end  = 15'(r_dst) + 15'(r_left);
    assign addr_err = (r_addr >= MEM_BYTES);
    assign src_err  = (src_end > TOTAL_BITS);
    assign dst_err  = (dst_end > TOTAL_BITS);
    assign is_fill  = (r_cmd == CMD_ZERO) || (r_cmd == CMD_ONE);

    always_comb begin
        o_stat.is_write  = (r_cmd == CMD_WRITE);
        o_stat.is_read   = (r_cmd == CMD_READ);
        o_stat.is_copy   = (r_cmd == CMD_COPY);
        o_stat.is_fill   = is_fill;
        o_stat.err       = ((o_stat.is_write || o_stat.is_read) && addr_err)
                         || (o_stat.is_copy && (src_err || dst_err))
                         || (is_fill && dst_err);
        o_stat.left_zero = (r_left == 14'd0);
        o_stat.spill     = (reach > 5'd8);
    end

    // The chunk spans at most two bytes, so both ports read a byte pair.
    always_comb begin
        priority if (i_ctl.rd_byte) begin
            ra_a = AW'(r_addr);
            ra_b = AW'(r_addr);
        end else if (i_ctl.rd_src) begin
            ra_a = src_idx;
            ra_b = src_idx + AW'(1);
        end else if (i_ctl.rd_dst) begin
            ra_a = dst_idx;
            ra_b = dst_idx + AW'(1);
        end else begin
            ra_a = AW'(r_addr);
            ra_b = AW'(r_addr);
        end
    end

    assign src_word = {rd_b, rd_a} >> r_src[2:0];
    assign dst_word = {rd_b, rd_a};
    assign len_mask = (9'd1 << len) - 9'd1;
    assign mask16   = 16'(len_mask) << r_dst[2:0];
    assign data16   = 16'(r_chunk) << r_dst[2:0];
    assign merged   = (dst_word & ~mask16) | (data16 & mask16);

    always_comb begin
        we    = i_ctl.wr_byte || i_ctl.wr_lo || i_ctl.wr_hi;
        priority if (i_ctl.wr_byte) begin
            waddr = AW'(r_addr);
            wdata = r_data;
        end else if (i_ctl.wr_lo) begin
            waddr = dst_idx;
            wdata = merged[7:0];
        end else begin
            waddr = r_hi_addr;
            wdata = r_hi_data;
        end
    end

    bgce_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (ra_a),
        .i_raddr_b (ra_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd     <= i_item.command;
            r_addr    <= i_item.byte_address;
            r_data    <= i_item.byte_data;
            r_src     <= (i_item.command == CMD_COPY) ? CUR_W'(i_item.src_bit_offset)
                                                      : '0;
            r_dst     <= CUR_W'(i_item.dst_bit_offset);
            r_left    <= i_item.bit_count;
            r_rd_data <= '0;
            r_status  <= 1'b0;
        end else begin
            if (i_ctl.decode) begin
                r_status <= o_stat.err;
            end
            if (i_ctl.cap_rd) begin
                r_rd_data <= rd_a;
            end
            if (i_ctl.latch_chunk) begin
                if (o_stat.is_copy) begin
                    r_chunk <= src_word[7:0];
                end else begin
                    r_chunk <= (r_cmd == CMD_ONE) ? FILL_ONES : FILL_ZEROS;
                end
            end
            // Cursors move on once the low byte of the chunk is written.
            if (i_ctl.wr_lo) begin
                r_hi_data <= merged[15:8];
                r_hi_addr <= dst_idx + AW'(1);
                r_src     <= r_src + CUR_W'(len);
                r_dst     <= r_dst + CUR_W'(len);
                r_left    <= r_left - 14'(len);
            end
        end
    end

    assign o_result.read_data = r_rd_data;
    assign o_result.status    = r_status;

endmodule

`default_nettype wire

/* hdl/bit_granular_copy_engine.sv */
`default_nettype none

// Bit-granular copy and fill engine over a MEM_BYTES byte memory.
// A command word is taken on i_cmd at a rising edge where start is high
// and busy is low. Commands: write byte, read byte, copy bits, zero fill,
// one fill. Exactly one result word per command appears on o_result for
// one cycle, marked by o_valid; the receiver cannot hold it off.
// From the decode state, a write, a refused range or an unknown command
// goes straight to the result, a read byte passes through a capture
// state first, and a copy or fill works through chunks of up to 8 bits.
// Each chunk costs a source read (copies only), a destination read, and
// one or two masked byte writes through the single write port of the
// memory, the second only when the chunk crosses a destination byte
// boundary; reads of the memory are registered.
// busy drops in the result cycle, so the next command can be accepted at
// the edge that ends it. Reset returns the controller to idle; memory
// contents are undefined until written and no clearing pass is made.

module bit_granular_copy_engine
    import bgce_pkg::*;
#(
    parameter int MEM_BYTES = MEM_BYTES_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire t_in_item i_cmd,
    output logic          o_valid,
    output t_out_item     o_result
);

    t_dp_ctl  ctl;
    t_dp_stat stat;

    bgce_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .i_stat  (stat),
        .o_ctl   (ctl)
    );

    bgce_dp #(
        .MEM_BYTES (MEM_BYTES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_item   (i_cmd),
        .i_ctl    (ctl),
        .o_stat   (stat),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

/* dv/tb.sv */
`default_nettype none

module tb;
    import bgce_pkg::*;

    localparam int MEM_BYTES  = MEM_BYTES_DEF;
    localparam int TOTAL_BITS = MEM_BYTES * 8;
    localparam int HOT_BYTES  = 64;
    localparam int HOT_BITS   = HOT_BYTES * 8;
    localparam int MAX_COUNT  = 16383;

    localparam logic [2:0] CMD_RSVD_5 = 3'd5;
    localparam logic [2:0] CMD_RSVD_6 = 3'd6;
    localparam logic [2:0] CMD_RSVD_7 = 3'd7;

    localparam logic ST_DONE  = 1'b0;
    localparam logic ST_RANGE = 1'b1;

    typedef struct {
        t_in_item word;
        bit       hold;
    } t_queued_cmd;

    logic      i_clk    = 1'b0;
    logic      i_rst_n  = 1'b0;
    logic      start    = 1'b0;
    t_in_item  cmd_word = '0;
    logic      busy;
    logic      o_valid;
    t_out_item o_result;

    logic [7:0]  shadow_mem [MEM_BYTES];
    t_queued_cmd cmd_fifo[$];
    t_out_item   outstanding_results[$];
    t_out_item   want;
    int          n_sent = 0;
    int          n_done = 0;
    int          n_err  = 0;

    bit_granular_copy_engine #(
        .MEM_BYTES(MEM_BYTES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (cmd_word),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        n_err++;
    endtask

    // Moves n bits in ascending chunks of up to 8. Each chunk is gathered in
    // full before it is written, so an overlapping copy sees earlier chunks.
    function automatic void move_bits(input int unsigned s, input int unsigned d,
                                      input int unsigned n, input bit fill,
                                      input logic [7:0] fill_byte);
        int unsigned len;
        logic [7:0]  chunk;
        while (n != 0) begin
            len = (n > 8) ? 8 : n;
            chunk = fill_byte;
            if (!fill) begin
                for (int unsigned i = 0; i < len; i++) begin
                    chunk[i] = shadow_mem[(s + i) / 8][(s + i) % 8];
                end
            end
            for (int unsigned i = 0; i < len; i++) begin
                shadow_mem[(d + i) / 8][(d + i) % 8] = chunk[i];
            end
            s += len;
            d += len;
            n -= len;
        end
    endfunction

    function automatic t_out_item run_command(input t_in_item w);
        t_out_item   r;
        int unsigned src;
        int unsigned dst;
        int unsigned cnt;
        r = '0;
        src = 32'(w.src_bit_offset);
        dst = 32'(w.dst_bit_offset);
        cnt = 32'(w.bit_count);
        case (w.command)
            CMD_WRITE: begin
                if (w.byte_address >= MEM_BYTES) r.status = ST_RANGE;
                else shadow_mem[w.byte_address] = w.byte_data;
            end
            CMD_READ: begin
                if (w.byte_address >= MEM_BYTES) r.status = ST_RANGE;
                else r.read_data = shadow_mem[w.byte_address];
            end
            CMD_COPY: begin
                if (src + cnt > TOTAL_BITS || dst + cnt > TOTAL_BITS) r.status = ST_RANGE;
                else move_bits(src, dst, cnt, 1'b0, FILL_ZEROS);
            end
            CMD_ZERO, CMD_ONE: begin
                // The constant source of a fill is never range checked.
                if (dst + cnt > TOTAL_BITS) r.status = ST_RANGE;
                else move_bits(0, dst, cnt, 1'b1,
                               (w.command == CMD_ONE) ? FILL_ONES : FILL_ZEROS);
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic t_in_item form_word(input logic [2:0] c, input logic [9:0] a,
                                           input logic [7:0] d, input logic [12:0] s,
                                           input logic [12:0] t, input logic [13:0] n);
        t_in_item w;
        w.command        = c;
        w.byte_address   = a;
        w.byte_data      = d;
        w.src_bit_offset = s;
        w.dst_bit_offset = t;
        w.bit_count      = n;
        return w;
    endfunction

    // Sender: holds start until the word is taken, then idles at random
    // except through a stretch in the middle of the run with no random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                outstanding_results.push_back(run_command(cmd_word));
                n_sent++;
            end
            if (!start || !busy) begin
                if (cmd_fifo.size() != 0 && (!cmd_fifo[0].hold || n_sent == n_done) &&
                    ((n_sent >= 120 && n_sent < 180) || $urandom_range(0, 99) >= 31)) begin
                    cmd_word <= cmd_fifo[0].word;
                    void'(cmd_fifo.pop_front());
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (outstanding_results.size() == 0) begin
                flag_mismatch("result word with no command outstanding");
            end else begin
                want = outstanding_results.pop_front();
                n_done <= n_done + 1;
                if (o_result.read_data !== want.read_data) begin
                    flag_mismatch($sformatf("read_data %h, predicted %h",
                                            o_result.read_data, want.read_data));
                end
                if (o_result.status !== want.status) begin
                    flag_mismatch($sformatf("status %b, predicted %b",
                                            o_result.status, want.status));
                end
            end
        end
    end

    initial begin
        t_in_item    w;
        int unsigned roll;
        int unsigned cnt;
        int unsigned span;
        int unsigned lo;
        int          large_left;
        bit          hot;

        // The first fill is byte aligned and whole, so it defines every byte
        // whatever the bytes held before.
        cmd_fifo.push_back('{form_word(CMD_ONE, 0, 0, 8191, 0, 14'(TOTAL_BITS)), 1'b0});
        cmd_fifo.push_back('{form_word(CMD_READ, 0, 0, 0, 0, 0), 1'b0});
        cmd_fifo.push_back('{form_word(CMD_WRITE, 0, 8'h00, 0, 0, 0), 1'b0});
        cmd_fifo.push_back('{form_word(CMD_WRITE, 10'(MEM_BYTES - 1), 8'hA5, 0, 0, 0),
                             1'b0});
        cmd_fifo.push_back('{form_word(CMD_WRITE, 1, 8'h3C, 0, 0, 0), 1'b0});
        cmd_fifo.push_back('{form_word(CMD_READ, 10'(MEM_BYTES - 1), 0, 0, 0, 0), 1'b0});
        cmd_fifo.push_back('{form_word(CMD_COPY, 0, 0, 8184, 0, 8), 1'b0});
        cmd_fifo.push_back('{form_word(CMD_COPY, 0, 0, 3, 13, 21), 1'b0});
        cmd_fifo.push_back('{form_word(CMD_COPY, 0, 0, 4, 9, 40), 1'b0});
        cmd_fifo.push_back('{form_word(CMD_COPY, 0, 0, 20, 11, 40), 1'b0});
        cmd_fifo.push_back('{form_word(CMD_COPY, 0, 0, 8191, 8191, 0), 1'b0});
        cmd_fifo.push_back('{form_word(CMD_COPY, 0, 0, 8191, 0, 1), 1'b0});
        cmd_fifo.push_back('{form_word(CMD_COPY, 0, 0, 8191, 0, 2), 1'b0});
        cmd_fifo.push_back('{form_word(CMD_COPY, 0, 0, 0, 8190, 3), 1'b0});
        cmd_fifo.push_back('{form_word(CMD_COPY, 0, 0, 1, 0, 14'(TOTAL_BITS)), 1'b0});
        cmd_fifo.push_back('{form_word(CMD_COPY, 0, 0, 0, 0, 14'(MAX_COUNT)), 1'b0});
        cmd_fifo.push_back('{form_word(CMD_ZERO, 0, 0, 8191, 5, 19), 1'b0});
        cmd_fifo.push_back('{form_word(CMD_ONE, 0, 0, 0, 8000, 193), 1'b0});
        cmd_fifo.push_back('{form_word(CMD_ONE, 0, 0, 0, 8000, 192), 1'b0});
        cmd_fifo.push_back('{form_word(CMD_ZERO, 0, 0, 0, 0, 0), 1'b0});
        cmd_fifo.push_back('{form_word(CMD_RSVD_5, 7, 8'h11, 8, 9, 10), 1'b0});
        cmd_fifo.push_back('{form_word(CMD_RSVD_6, '1, '1, '1, '1, '1), 1'b0});
        cmd_fifo.push_back('{form_word(CMD_RSVD_7, 0, 0, 0, 0, 0), 1'b0});
        cmd_fifo.push_back('{form_word(CMD_COPY, 0, 0, 0, 0, 14'(TOTAL_BITS)), 1'b0});
        cmd_fifo.push_back('{form_word(CMD_READ, 2, 0, 0, 0, 0), 1'b0});

        // Most traffic lands in a small hot region so that writes, fills and
        // copies keep reshaping the same bytes.
        large_left = 6;
        for (int k = 0; k < 290; k++) begin
            w.command        = CMD_WRITE;
            w.byte_address   = 10'($urandom_range(0, MEM_BYTES - 1));
            w.byte_data      = 8'($urandom_range(0, 255));
            w.src_bit_offset = 13'($urandom_range(0, TOTAL_BITS - 1));
            w.dst_bit_offset = 13'($urandom_range(0, TOTAL_BITS - 1));
            w.bit_count      = 14'($urandom_range(0, MAX_COUNT));
            roll = $urandom_range(0, 99);
            hot  = $urandom_range(0, 99) < 65;
            if (roll < 36) begin
                w.command = (roll < 18) ? CMD_WRITE : CMD_READ;
                if (hot) w.byte_address = 10'($urandom_range(0, HOT_BYTES - 1));
            end else if (roll < 86) begin
                if (roll < 66) w.command = CMD_COPY;
                else if (roll < 76) w.command = CMD_ZERO;
                else w.command = CMD_ONE;
                if (large_left > 0 && $urandom_range(0, 99) < 3) begin
                    cnt = $urandom_range(97, TOTAL_BITS);
                    large_left--;
                end else if ($urandom_range(0, 99) < 75) begin
                    cnt = $urandom_range(0, 24);
                end else begin
                    cnt = $urandom_range(25, 96);
                end
                span = (hot && cnt <= HOT_BITS) ? HOT_BITS : TOTAL_BITS;
                lo = span - cnt;
                if (lo > TOTAL_BITS - 1) lo = TOTAL_BITS - 1;
                w.bit_count      = 14'(cnt);
                w.src_bit_offset = 13'($urandom_range(0, lo));
                w.dst_bit_offset = 13'($urandom_range(0, lo));
            end else if (roll < 91) begin
                w.command = 3'($urandom_range(CMD_RSVD_5, CMD_RSVD_7));
            end else begin
                // A copy or fill whose source or destination runs past the end.
                w.command = 3'($urandom_range(CMD_COPY, CMD_ONE));
                cnt = $urandom_range(2, TOTAL_BITS);
                w.bit_count = 14'(cnt);
                lo = TOTAL_BITS + 1 - cnt;
                if (w.command == CMD_COPY && $urandom_range(0, 1) == 1) begin
                    w.src_bit_offset = 13'($urandom_range(lo, TOTAL_BITS - 1));
                end else begin
                    w.dst_bit_offset = 13'($urandom_range(lo, TOTAL_BITS - 1));
                end
            end
            cmd_fifo.push_back('{w, (k % 70 == 69)});
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_fifo.size() != 0 || start || n_done != n_sent) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (outstanding_results.size() != 0) begin
            flag_mismatch($sformatf("%0d result words never arrived",
                                    outstanding_results.size()));
        end
        if (n_err == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
